// ===== hdl/ramr_pkg.sv =====
// shared types and constants for the rational add, multiply and reduce block
package ramr_pkg;

   // opcodes carried on the request side
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_RED = 2'd2;

   // result field widths and packing
   localparam int NUM_WIDTH        = 33;
   localparam int DEN_WIDTH        = 32;
   localparam int OUT_TDATA_WIDTH  = ((NUM_WIDTH + DEN_WIDTH + 7) / 8) * 8;
   localparam int OUT_PAD          = OUT_TDATA_WIDTH - NUM_WIDTH - DEN_WIDTH;

   // control for the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;       // issue a product this cycle
      logic accumulate;  // add onto the running sum instead of replacing it
   } mul_req_type;

endpackage

// ===== hdl/ramr_mul.sv =====
// shared signed multiplier with registered product and accumulate stage
module ramr_mul
   import ramr_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16,
   parameter int ACC_WIDTH     = 33
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mul_req_type                   req,
   input  logic signed [OPERAND_WIDTH-1:0] op_a,
   input  logic signed [OPERAND_WIDTH-1:0] op_b,
   output logic signed [ACC_WIDTH-1:0]   acc
);

   logic signed [2*OPERAND_WIDTH-1:0] prod_in;
   logic signed [2*OPERAND_WIDTH-1:0] prod_ff;
   mul_req_type                       req_ff;
   logic signed [ACC_WIDTH-1:0]       acc_ff;
   logic signed [ACC_WIDTH-1:0]       acc_in;
   logic signed [ACC_WIDTH-1:0]       prod_ext;

   assign prod_in  = op_a * op_b;
   assign prod_ext = ACC_WIDTH'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (req_ff.valid) begin
         acc_in = req_ff.accumulate ? (acc_ff + prod_ext) : prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= '0;
      end else begin
         req_ff <= req;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== hdl/rational_add_multiply_reduce_top.sv =====
// top level: fraction add, multiply or reduce with gcd reduction of the result
//
//  channel  direction  ports                         contents
//  req      in         req_tvalid/tready/tdata/tuser opcode on tuser, two fractions on tdata
//  rsp      out        rsp_tvalid/tready/tdata       reduced numerator and denominator
//
// one item at a time: req_tready is high only while the sequencer is idle
// add and multiply use the shared multiplier, reduce skips it; then come the set-up
// state, the binary gcd loop (one shift or subtract a cycle) and two restoring
// divisions, one for the numerator and one for the denominator
// when neither part is positive the item leaves after the set-up state, and when the
// gcd is below 2 it leaves as soon as the gcd loop ends
// a finished result sits in the output register; the next transfer is taken
// while it waits, and only the final hand-over stalls on rsp_tready
// reset is synchronous and clears the sequencer, the output valid and the
// multiplier issue flag only
module rational_add_multiply_reduce_top
   import ramr_pkg::*;
#(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // request side
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // a_num, a_den, b_num, b_den from the lowest bit up, zero padded to bytes
   input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]         req_tdata,
   // opcode
   input  logic [1:0]                                   req_tuser,
   // result side
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // result_num (33 bits), result_den (32 bits) from the lowest bit up, zero padded
   output logic [OUT_TDATA_WIDTH-1:0]                   rsp_tdata
);

   // internal width: exact sum of two products, wrapping at 64 bits
   localparam int IW = (2*OPERAND_WIDTH + 1 > 64) ? 64 : 2*OPERAND_WIDTH + 1;
   localparam int SW = IW + 2;              // shared subtractor width
   localparam int CW = $clog2(IW + 1);      // step and shift counters

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_GCD  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // magnitude of a signed value as an unsigned word of the same width
   function automatic logic [IW-1:0] mag(input logic [IW-1:0] v);
      mag = v[IW-1] ? (~v + 1'b1) : v;
   endfunction

   // unpacked request fields
   logic signed [OPERAND_WIDTH-1:0] req_a_num;
   logic signed [OPERAND_WIDTH-1:0] req_a_den;
   logic signed [OPERAND_WIDTH-1:0] req_b_num;
   logic signed [OPERAND_WIDTH-1:0] req_b_den;

   assign req_a_num = req_tdata[OPERAND_WIDTH-1:0];
   assign req_a_den = req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
   assign req_b_num = req_tdata[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH];
   assign req_b_den = req_tdata[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH];

   // registers
   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   step_ff, step_in;
   logic [CW-1:0]                   k_ff, k_in;
   logic [1:0]                      opcode_ff, opcode_in;
   logic signed [OPERAND_WIDTH-1:0] an_ff, an_in;
   logic signed [OPERAND_WIDTH-1:0] ad_ff, ad_in;
   logic signed [OPERAND_WIDTH-1:0] bn_ff, bn_in;
   logic signed [OPERAND_WIDTH-1:0] bd_ff, bd_in;
   logic signed [IW-1:0]            n_ff, n_in;
   logic signed [IW-1:0]            d_ff, d_in;
   logic [IW-1:0]                   x_ff, x_in;
   logic [IW-1:0]                   y_ff, y_in;
   logic [IW-1:0]                   g_ff, g_in;
   logic [IW-1:0]                   r_ff, r_in;
   logic [IW-1:0]                   q_ff, q_in;
   logic                            sel_ff, sel_in;
   logic signed [IW-1:0]            rn_ff, rn_in;
   logic signed [IW-1:0]            rd_ff, rd_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [OUT_TDATA_WIDTH-1:0]      rsp_data_ff, rsp_data_in;

   // shared multiplier
   mul_req_type                     mul_req;
   logic signed [OPERAND_WIDTH-1:0] mul_a;
   logic signed [OPERAND_WIDTH-1:0] mul_b;
   logic signed [IW-1:0]            mul_acc;

   ramr_mul #(
      .OPERAND_WIDTH (OPERAND_WIDTH),
      .ACC_WIDTH     (IW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .acc   (mul_acc)
   );

   // shared subtractor: gcd compare/subtract and restoring division step
   logic [SW-1:0] sub_a;
   logic [SW-1:0] sub_b;
   logic [SW-1:0] sub_diff;
   logic          sub_ge;

   assign sub_diff = sub_a - sub_b;
   assign sub_ge   = !sub_diff[SW-1];

   // gcd result once one operand has reached zero
   logic [IW-1:0] g_odd;
   logic [IW-1:0] g_sh;
   logic [IW-1:0] q_fin;
   logic          any_pos;
   logic signed [63:0] rn_ext;
   logic signed [63:0] rd_ext;

   assign g_odd   = (x_ff == '0) ? y_ff : x_ff;
   assign g_sh    = g_odd << k_ff;
   assign q_fin   = {q_ff[IW-2:0], sub_ge};
   // true when at least one of numerator and denominator is positive
   assign any_pos = (!n_ff[IW-1] && (n_ff != '0)) || (!d_ff[IW-1] && (d_ff != '0));
   assign rn_ext  = 64'(rn_ff);
   assign rd_ext  = 64'(rd_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      opcode_in    = opcode_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      sel_in       = sel_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_req      = '0;
      mul_a        = ad_ff;
      mul_b        = bd_ff;
      sub_a        = '0;
      sub_b        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               opcode_in = req_tuser;
               an_in     = req_a_num;
               ad_in     = req_a_den;
               bn_in     = req_b_num;
               bd_in     = req_b_den;
               step_in   = '0;
               if (req_tuser inside {OP_ADD, OP_MUL}) begin
                  state_in = S_MUL;
               end else begin
                  // reduce and the unused code take fraction a as it is
                  n_in     = IW'(req_a_num);
                  d_in     = IW'(req_a_den);
                  state_in = S_PREP;
               end
            end
         end

         S_MUL: begin
            // product is registered in prod_ff, then lands in the accumulator acc_ff
            step_in = step_ff + 1'b1;
            case (step_ff)
               CW'(0): begin
                  mul_req.valid = 1'b1;
                  mul_a         = ad_ff;
                  mul_b         = bd_ff;
               end
               CW'(1): begin
                  mul_req.valid = 1'b1;
                  mul_a         = an_ff;
                  mul_b         = (opcode_ff == OP_MUL) ? bn_ff : bd_ff;
               end
               CW'(2): begin
                  d_in = mul_acc;
                  if (opcode_ff == OP_ADD) begin
                     mul_req.valid      = 1'b1;
                     mul_req.accumulate = 1'b1;
                     mul_a              = bn_ff;
                     mul_b              = ad_ff;
                  end
               end
               CW'(4): begin
                  n_in     = mul_acc;
                  state_in = S_PREP;
               end
               default: begin
               end
            endcase
         end

         S_PREP: begin
            x_in  = mag(n_ff);
            y_in  = mag(d_ff);
            k_in  = '0;
            rn_in = n_ff;
            rd_in = d_ff;
            state_in = any_pos ? S_GCD : S_OUT;
         end

         S_GCD: begin
            if ((x_ff == '0) || (y_ff == '0)) begin
               if (g_sh < IW'(2)) begin
                  state_in = S_OUT;
               end else begin
                  g_in     = g_sh;
                  q_in     = mag(n_ff);
                  r_in     = '0;
                  step_in  = CW'(IW);
                  sel_in   = 1'b0;
                  state_in = S_DIV;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else begin
               // both odd: subtract the smaller, or swap so the next pass can
               sub_a = {2'b00, x_ff};
               sub_b = {2'b00, y_ff};
               if (sub_ge) begin
                  x_in = sub_diff[IW-1:0];
               end else begin
                  x_in = y_ff;
                  y_in = x_ff;
               end
            end
         end

         S_DIV: begin
            // restoring division, one quotient bit a cycle
            sub_a   = {1'b0, r_ff, q_ff[IW-1]};
            sub_b   = {2'b00, g_ff};
            r_in    = sub_ge ? sub_diff[IW-1:0] : {r_ff[IW-2:0], q_ff[IW-1]};
            q_in    = q_fin;
            step_in = step_ff - 1'b1;
            if (step_ff == CW'(1)) begin
               if (!sel_ff) begin
                  rn_in   = n_ff[IW-1] ? (~q_fin + 1'b1) : q_fin;
                  q_in    = mag(d_ff);
                  r_in    = '0;
                  step_in = CW'(IW);
                  sel_in  = 1'b1;
               end else begin
                  rd_in    = d_ff[IW-1] ? (~q_fin + 1'b1) : q_fin;
                  state_in = S_OUT;
               end
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{OUT_PAD{1'b0}}, rd_ext[DEN_WIDTH-1:0],
                               rn_ext[NUM_WIDTH-1:0]};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      k_ff        <= k_in;
      opcode_ff   <= opcode_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      g_ff        <= g_in;
      r_ff        <= r_in;
      q_ff        <= q_in;
      sel_ff      <= sel_in;
      rn_ff       <= rn_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
